// ===== src/tcspm_pkg.sv =====
// shared types and constants of the two-channel spectrum peak mask block
// used by every module of the block; no dependencies
`timescale 1ns / 1ps

package tcspm_pkg;

    // default configuration
    localparam int LOG2_BINS_DEF   = 10;
    localparam int SAMPLE_BITS_DEF = 24;

    // fixed field widths
    localparam int SAMPLE_W  = 24;
    localparam int POW_W     = 50;
    localparam int BIN_IDX_W = 10;
    localparam int BIN9_W    = 9;
    localparam int CNT_W     = 10;

    // ((1 + sqrt 2) / 2)^2 in q1.16
    localparam int          SCALE_W   = 17;
    localparam logic [16:0] SCALE_Q16 = 17'd95493;
    localparam int          FRAC_W    = 16;

    // front to back queue
    localparam int QUEUE_DEPTH = 4;

    // record codes
    localparam logic KIND_BIN     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;
    localparam logic CH_A         = 1'b0;
    localparam logic CH_B         = 1'b1;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [POW_W-1:0]     lim_a;
        logic [POW_W-1:0]     lim_b;
        logic [BIN_IDX_W-1:0] bin_index;
        logic                 start;
        logic                 pos;
        logic                 fin;
    } t_bin_meta;

    typedef struct packed {
        t_bin_meta        meta;
        logic [POW_W-1:0] power_a;
        logic [POW_W-1:0] power_b;
    } t_bin_item;

    typedef struct packed {
        logic                 record_kind;
        logic                 channel;
        logic [BIN_IDX_W-1:0] bin_index;
        logic [POW_W-1:0]     power_a;
        logic [POW_W-1:0]     power_b;
        logic                 peak_found;
        logic [BIN9_W-1:0]    peak_bin;
        logic [POW_W-1:0]     peak_power;
        logic [CNT_W-1:0]     violation_count;
        logic [BIN9_W-1:0]    first_violation_bin;
        logic [BIN9_W-1:0]    last_violation_bin;
        logic                 last_result;
    } t_result;

endpackage

// ===== src/tcspm_front.sv =====
// front part: bin counting, spectrum separation and scaled power pipeline
// depends on tcspm_pkg
`timescale 1ns / 1ps

module tcspm_front #(
    parameter int LOG2_BINS   = tcspm_pkg::LOG2_BINS_DEF,
    parameter int SAMPLE_BITS = tcspm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_push,
    output logic                                    o_full,
    input  logic signed [tcspm_pkg::SAMPLE_W-1:0]   i_re_this_bin,
    input  logic signed [tcspm_pkg::SAMPLE_W-1:0]   i_im_this_bin,
    input  logic signed [tcspm_pkg::SAMPLE_W-1:0]   i_re_mirror_bin,
    input  logic signed [tcspm_pkg::SAMPLE_W-1:0]   i_im_mirror_bin,
    input  logic        [tcspm_pkg::POW_W-1:0]      i_mask_limit_a,
    input  logic        [tcspm_pkg::POW_W-1:0]      i_mask_limit_b,
    input  logic                                    i_final_bin,
    input  logic                                    i_q_full,
    output logic                                    o_q_push,
    output tcspm_pkg::t_bin_item                    o_q_data
);
    import tcspm_pkg::*;

    localparam int SUM_W  = SAMPLE_BITS + 1;
    localparam int SQ_W   = 2 * SUM_W;
    localparam int SS_W   = SQ_W + 1;
    localparam int HI_W   = SS_W - FRAC_W;
    localparam int PROD_W = HI_W + SCALE_W;
    localparam int LO_W   = FRAC_W + SCALE_W;
    localparam int BW     = (LOG2_BINS > BIN_IDX_W) ? LOG2_BINS : BIN_IDX_W;

    logic                       w_en;
    logic                       w_accept;
    logic [LOG2_BINS-1:0]       r_bin_cnt;
    logic [BW-1:0]              w_bin_wide;

    logic signed [SAMPLE_BITS-1:0] w_rk, w_ik, w_rm, w_im;
    logic signed [SUM_W-1:0]       w_x [4];

    t_bin_meta                  n_meta;
    logic [3:0][SUM_W-1:0]      n_mag;
    logic [3:0][SQ_W-1:0]       n_sq;
    logic [1:0][SS_W-1:0]       n_sum;
    logic [1:0][LO_W-1:0]       n_lo_prod;
    logic [1:0][PROD_W-1:0]     n_hp;
    logic [1:0][SCALE_W-1:0]    n_lp;

    logic                       r_s1_valid, r_s2_valid, r_s3_valid;
    t_bin_meta                  r_s1_meta, r_s2_meta, r_s3_meta;
    logic [3:0][SUM_W-1:0]      r_s1_mag;
    logic [3:0][SQ_W-1:0]       r_s2_sq;
    logic [1:0][PROD_W-1:0]     r_s3_hp;
    logic [1:0][SCALE_W-1:0]    r_s3_lp;

    // whole pipeline moves together, held only when the last stage cannot leave
    assign w_en     = !r_s3_valid || !i_q_full;
    assign o_full   = !w_en;
    assign w_accept = i_push && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_cnt <= '0;
        end else if (w_accept) begin
            r_bin_cnt <= i_final_bin ? '0 : r_bin_cnt + 1'b1;
        end
    end

    assign w_bin_wide = BW'(r_bin_cnt);

    always_comb begin
        n_meta.lim_a     = i_mask_limit_a;
        n_meta.lim_b     = i_mask_limit_b;
        n_meta.bin_index = w_bin_wide[BIN_IDX_W-1:0];
        n_meta.start     = (r_bin_cnt == '0);
        n_meta.pos       = !r_bin_cnt[LOG2_BINS-1];
        n_meta.fin       = i_final_bin;
    end

    assign w_rk = i_re_this_bin[SAMPLE_BITS-1:0];
    assign w_ik = i_im_this_bin[SAMPLE_BITS-1:0];
    assign w_rm = i_re_mirror_bin[SAMPLE_BITS-1:0];
    assign w_im = i_im_mirror_bin[SAMPLE_BITS-1:0];

    // channel a from the even part, channel b from the odd part
    assign w_x[0] = SUM_W'(w_rk) + SUM_W'(w_rm);
    assign w_x[1] = SUM_W'(w_ik) - SUM_W'(w_im);
    assign w_x[2] = SUM_W'(w_ik) + SUM_W'(w_im);
    assign w_x[3] = SUM_W'(w_rm) - SUM_W'(w_rk);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_mag[i] = w_x[i][SUM_W-1] ? SUM_W'(-w_x[i]) : SUM_W'(w_x[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_sq[i] = SQ_W'(r_s1_mag[i]) * SQ_W'(r_s1_mag[i]);
        end
    end

    // scale split in a high and a low part so the product stays narrow
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            n_sum[c]     = SS_W'(r_s2_sq[2*c]) + SS_W'(r_s2_sq[2*c+1]);
            n_hp[c]      = PROD_W'(n_sum[c][SS_W-1:FRAC_W]) * PROD_W'(SCALE_Q16);
            n_lo_prod[c] = LO_W'(n_sum[c][FRAC_W-1:0]) * LO_W'(SCALE_Q16);
            n_lp[c]      = n_lo_prod[c][LO_W-1:FRAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_meta <= n_meta;
            r_s1_mag  <= n_mag;
            r_s2_meta <= r_s1_meta;
            r_s2_sq   <= n_sq;
            r_s3_meta <= r_s2_meta;
            r_s3_hp   <= n_hp;
            r_s3_lp   <= n_lp;
        end
    end

    assign o_q_push         = r_s3_valid && !i_q_full;
    assign o_q_data.meta    = r_s3_meta;
    assign o_q_data.power_a = POW_W'(r_s3_hp[0] + PROD_W'(r_s3_lp[0]));
    assign o_q_data.power_b = POW_W'(r_s3_hp[1] + PROD_W'(r_s3_lp[1]));

endmodule

// ===== src/tcspm_queue.sv =====
// short register queue between the front and back parts
// depends on tcspm_pkg
`timescale 1ns / 1ps

module tcspm_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  tcspm_pkg::t_bin_item  i_data,
    output logic                  o_full,
    input  logic                  i_pop,
    output tcspm_pkg::t_bin_item  o_data,
    output logic                  o_empty
);
    import tcspm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_bin_item          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W:0]     r_count;
    logic               w_wr;
    logic               w_rd;

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== src/tcspm_back.sv =====
// back part: peak and mask statistics, record sequencing and output register
// depends on tcspm_pkg
`timescale 1ns / 1ps

module tcspm_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tcspm_pkg::POW_W-1:0]        i_cfg_wdata,
    input  logic                               i_q_empty,
    input  tcspm_pkg::t_bin_item               i_q_data,
    output logic                               o_q_pop,
    input  logic                               i_pop,
    output logic                               o_res_valid,
    output tcspm_pkg::t_result                 o_res
);
    import tcspm_pkg::*;

    typedef enum logic [2:0] {
        ST_BIN   = 3'b001,
        ST_SUM_A = 3'b010,
        ST_SUM_B = 3'b100
    } t_back_state;

    t_back_state             r_state, n_state;
    logic [POW_W-1:0]        r_min_peak;

    logic [1:0][POW_W-1:0]   r_best_power, n_best_power;
    logic [1:0][BIN9_W-1:0]  r_best_bin, n_best_bin;
    logic [1:0]              r_best_valid, n_best_valid;
    logic [1:0][CNT_W-1:0]   r_mask_count, n_mask_count;
    logic [1:0][BIN9_W-1:0]  r_first_bad, n_first_bad;
    logic [1:0][BIN9_W-1:0]  r_last_bad, n_last_bad;

    logic [1:0][POW_W-1:0]   w_pow;
    logic [1:0][POW_W-1:0]   w_lim;
    logic [BIN9_W-1:0]       w_bin9;
    logic                    w_load;
    logic                    w_fire;
    logic                    w_ch;
    t_result                 r_res, n_res;
    logic                    r_res_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_peak <= POW_W'(1);
        end else if (i_cfg_valid) begin
            r_min_peak <= i_cfg_wdata;
        end
    end

    // output register frees up on a pop, summaries need no queue entry
    assign w_load  = !r_res_valid || i_pop;
    assign w_fire  = (r_state == ST_BIN) ? !i_q_empty : 1'b1;
    assign o_q_pop = (r_state == ST_BIN) && !i_q_empty && w_load;

    assign w_pow[0] = i_q_data.power_a;
    assign w_pow[1] = i_q_data.power_b;
    assign w_lim[0] = i_q_data.meta.lim_a;
    assign w_lim[1] = i_q_data.meta.lim_b;
    assign w_bin9   = i_q_data.meta.bin_index[BIN9_W-1:0];

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            if (i_q_data.meta.start) begin
                n_best_power[c] = r_min_peak;
                n_best_bin[c]   = '0;
                n_best_valid[c] = 1'b0;
                n_mask_count[c] = '0;
                n_first_bad[c]  = '0;
                n_last_bad[c]   = '0;
            end else begin
                n_best_power[c] = r_best_power[c];
                n_best_bin[c]   = r_best_bin[c];
                n_best_valid[c] = r_best_valid[c];
                n_mask_count[c] = r_mask_count[c];
                n_first_bad[c]  = r_first_bad[c];
                n_last_bad[c]   = r_last_bad[c];
            end
            if (i_q_data.meta.pos) begin
                if (w_pow[c] > n_best_power[c]) begin
                    n_best_power[c] = w_pow[c];
                    n_best_bin[c]   = w_bin9;
                    n_best_valid[c] = 1'b1;
                end
                if (w_pow[c] > w_lim[c]) begin
                    if (n_mask_count[c] == '0) begin
                        n_first_bad[c] = w_bin9;
                    end
                    n_last_bad[c] = w_bin9;
                    if (n_mask_count[c] != CNT_MAX) begin
                        n_mask_count[c] = n_mask_count[c] + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_power <= {POW_W'(1), POW_W'(1)};
            r_best_bin   <= '0;
            r_best_valid <= '0;
            r_mask_count <= '0;
            r_first_bad  <= '0;
            r_last_bad   <= '0;
        end else if (o_q_pop) begin
            r_best_power <= n_best_power;
            r_best_bin   <= n_best_bin;
            r_best_valid <= n_best_valid;
            r_mask_count <= n_mask_count;
            r_first_bad  <= n_first_bad;
            r_last_bad   <= n_last_bad;
        end
    end

    assign w_ch = (r_state == ST_SUM_B) ? CH_B : CH_A;

    always_comb begin
        n_res   = '0;
        n_state = r_state;
        case (r_state)
            ST_BIN: begin
                n_res.record_kind = KIND_BIN;
                n_res.bin_index   = i_q_data.meta.bin_index;
                n_res.power_a     = i_q_data.power_a;
                n_res.power_b     = i_q_data.power_b;
                n_res.last_result = !i_q_data.meta.fin;
                n_state           = i_q_data.meta.fin ? ST_SUM_A : ST_BIN;
            end
            ST_SUM_A, ST_SUM_B: begin
                n_res.record_kind         = KIND_SUMMARY;
                n_res.channel             = w_ch;
                n_res.peak_found          = r_best_valid[w_ch];
                n_res.peak_bin            = r_best_bin[w_ch];
                n_res.peak_power          = r_best_power[w_ch];
                n_res.violation_count     = r_mask_count[w_ch];
                n_res.first_violation_bin = r_first_bad[w_ch];
                n_res.last_violation_bin  = r_last_bad[w_ch];
                n_res.last_result         = (w_ch == CH_B);
                n_state                   = (w_ch == CH_B) ? ST_BIN : ST_SUM_B;
            end
            default: begin
                n_state = ST_BIN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_BIN;
            r_res_valid <= 1'b0;
        end else if (w_load) begin
            r_res_valid <= w_fire;
            if (w_fire) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && w_fire) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ===== src/two_channel_spectrum_peak_mask.sv =====
// two-channel spectrum peak and mask block: separates two real spectra from one fft
// path: push, stages s1 to s3, the queue, then the output register and result ports
// throughput: one bin per cycle, set by the power pipeline, while pop keeps up; a
//   final bin holds the back part for a bin record and two summaries (queue absorbs)
// reset: synchronous, active low; clears pipeline, queue, statistics and bin counter,
//   floor register to 1; no clearing pass
`timescale 1ns / 1ps

module two_channel_spectrum_peak_mask #(
    parameter int LOG2_BINS   = tcspm_pkg::LOG2_BINS_DEF,
    parameter int SAMPLE_BITS = tcspm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write channel, floor for the peak search
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic        [tcspm_pkg::POW_W-1:0]     i_cfg_wdata,
    // input queue side
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [tcspm_pkg::SAMPLE_W-1:0]  i_re_this_bin,
    input  logic signed [tcspm_pkg::SAMPLE_W-1:0]  i_im_this_bin,
    input  logic signed [tcspm_pkg::SAMPLE_W-1:0]  i_re_mirror_bin,
    input  logic signed [tcspm_pkg::SAMPLE_W-1:0]  i_im_mirror_bin,
    input  logic        [tcspm_pkg::POW_W-1:0]     i_mask_limit_a,
    input  logic        [tcspm_pkg::POW_W-1:0]     i_mask_limit_b,
    input  logic                                   i_final_bin,
    // result queue side
    output logic                                   empty,
    input  logic                                   pop,
    output logic                                   o_record_kind,
    output logic                                   o_channel,
    output logic        [tcspm_pkg::BIN_IDX_W-1:0] o_bin_index,
    output logic        [tcspm_pkg::POW_W-1:0]     o_power_a,
    output logic        [tcspm_pkg::POW_W-1:0]     o_power_b,
    output logic                                   o_peak_found,
    output logic        [tcspm_pkg::BIN9_W-1:0]    o_peak_bin,
    output logic        [tcspm_pkg::POW_W-1:0]     o_peak_power,
    output logic        [tcspm_pkg::CNT_W-1:0]     o_violation_count,
    output logic        [tcspm_pkg::BIN9_W-1:0]    o_first_violation_bin,
    output logic        [tcspm_pkg::BIN9_W-1:0]    o_last_violation_bin,
    output logic                                   o_last_result
);
    import tcspm_pkg::*;

    // front to queue
    logic       w_fq_push;
    logic       w_fq_full;
    t_bin_item  w_fq_data;

    // queue to back
    logic       w_qb_pop;
    logic       w_qb_empty;
    t_bin_item  w_qb_data;

    // back to ports
    logic       w_res_valid;
    t_result    w_res;

    // front: counts bins, tags frame start and positive half, computes both powers
    tcspm_front #(
        .LOG2_BINS   (LOG2_BINS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_re_this_bin   (i_re_this_bin),
        .i_im_this_bin   (i_im_this_bin),
        .i_re_mirror_bin (i_re_mirror_bin),
        .i_im_mirror_bin (i_im_mirror_bin),
        .i_mask_limit_a  (i_mask_limit_a),
        .i_mask_limit_b  (i_mask_limit_b),
        .i_final_bin     (i_final_bin),
        .i_q_full        (w_fq_full),
        .o_q_push        (w_fq_push),
        .o_q_data        (w_fq_data)
    );

    // decouples the power pipeline from the record sequencer
    tcspm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fq_push),
        .i_data  (w_fq_data),
        .o_full  (w_fq_full),
        .i_pop   (w_qb_pop),
        .o_data  (w_qb_data),
        .o_empty (w_qb_empty)
    );

    // back: statistics update per transaction, summaries after a final bin
    tcspm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (w_qb_empty),
        .i_q_data    (w_qb_data),
        .o_q_pop     (w_qb_pop),
        .i_pop       (pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // result ports straight from the output register
    assign empty                 = !w_res_valid;
    assign o_record_kind         = w_res.record_kind;
    assign o_channel             = w_res.channel;
    assign o_bin_index           = w_res.bin_index;
    assign o_power_a             = w_res.power_a;
    assign o_power_b             = w_res.power_b;
    assign o_peak_found          = w_res.peak_found;
    assign o_peak_bin            = w_res.peak_bin;
    assign o_peak_power          = w_res.peak_power;
    assign o_violation_count     = w_res.violation_count;
    assign o_first_violation_bin = w_res.first_violation_bin;
    assign o_last_violation_bin  = w_res.last_violation_bin;
    assign o_last_result         = w_res.last_result;

endmodule

// ===== src/tcspm_checker.sv =====
// port-level checks of the two-channel spectrum peak mask block, bound to the top level
// depends on tcspm_pkg and two_channel_spectrum_peak_mask
`timescale 1ns / 1ps

module tcspm_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   empty,
    input logic                                   pop,
    input logic                                   o_record_kind,
    input logic                                   o_channel,
    input logic        [tcspm_pkg::POW_W-1:0]     o_power_a,
    input logic                                   o_peak_found,
    input logic        [tcspm_pkg::BIN9_W-1:0]    o_peak_bin,
    input logic        [tcspm_pkg::CNT_W-1:0]     o_violation_count,
    input logic                                   o_last_result
);
    import tcspm_pkg::*;

    // a waiting transaction holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_power_a) && $stable(o_record_kind)))
        else $error("result changed while stalled");

    // summary of channel b follows the popped summary of channel a at once
    a_sum_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_record_kind == KIND_SUMMARY && o_channel == CH_A)
        |=> (!empty && o_record_kind == KIND_SUMMARY && o_channel == CH_B))
        else $error("summary b missing after summary a");

    // only the channel b summary closes a final bin
    a_sum_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_record_kind == KIND_SUMMARY) |-> (o_last_result == o_channel))
        else $error("summary last flag wrong");

    // bin records leave the summary fields at zero
    a_bin_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_record_kind == KIND_BIN)
        |-> (o_channel == CH_A && !o_peak_found && o_violation_count == '0))
        else $error("bin record carries summary data");

    // no peak means no peak bin
    a_no_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_record_kind == KIND_SUMMARY && !o_peak_found) |-> (o_peak_bin == '0))
        else $error("peak bin without peak");

endmodule

bind two_channel_spectrum_peak_mask tcspm_checker u_tcspm_checker (.*);
